// ===== sv/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam int unsigned CAP_REG_WIDTH = 7;
   localparam logic [CAP_REG_WIDTH-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic               func;
      logic signed [31:0] value;
   } spq_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [6:0]         count;
      logic signed [31:0] head_value;
   } spq_rsp_type;

   typedef struct packed {
      logic               ins;
      logic               del;
      logic signed [31:0] value;
   } spq_ctrl_type;

endpackage
`default_nettype wire

// ===== sv/spq_cell.sv =====
`default_nettype none
module spq_cell (
   input  logic                 clock,
   input  logic                 cmp_en,
   input  logic                 occupied,
   input  logic signed [31:0]   cmp_value,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  logic                 left_ge,
   input  logic signed [31:0]   left_entry,
   input  logic signed [31:0]   right_entry,
   output logic signed [31:0]   entry,
   output logic                 ge,
   output logic                 le,
   output logic                 match
);
   import spq_pkg::*;

   logic signed [31:0] entry_ff, entry_in;
   logic               ge_ff, ge_in;
   logic               le_ff, le_in;
   logic               match_ff, match_in;

   always_comb begin
      ge_in    = ge_ff;
      le_in    = le_ff;
      match_in = match_ff;
      if (cmp_en) begin
         ge_in    = !occupied || (cmp_value >= entry_ff);
         le_in    = occupied && (entry_ff <= cmp_value);
         match_in = occupied && (entry_ff == cmp_value);
      end
   end

   // insert: shift right behind the slot, load at the slot; delete: pull from the right
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (left_ge) begin
            entry_in = left_entry;
         end else if (ge_ff) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.del && le_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      ge_ff    <= ge_in;
      le_ff    <= le_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign ge    = ge_ff;
   assign le    = le_ff;
   assign match = match_ff;

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_ready  | spq_req_type (func, value)
// rsp     | out       | rsp_valid / rsp_ready  | spq_rsp_type (status, count, head_value)
// csr     | in        | csr_valid / csr_ready  | capacity, 7 bits
//
// Every cell compares against the value in the accept cycle, then the row shifts
// and the result register loads in the next one. A new item is accepted as the
// previous result leaves, so items never overlap. Synchronous reset empties the
// queue and sets capacity to 64; entries are not cleared. A stalled result holds
// and blocks the next item.
module sorted_priority_queue_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  spq_pkg::spq_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output spq_pkg::spq_rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [6:0]            csr_data
);
   import spq_pkg::*;

   localparam int W  = $clog2(CAPACITY + 1);
   localparam int CW = (W > CAP_REG_WIDTH) ? W : CAP_REG_WIDTH;

   logic                     busy_ff, busy_in;
   spq_req_type              item_ff, item_in;
   logic [W-1:0]             count_ff, count_in;
   logic [CAP_REG_WIDTH-1:0] capacity_ff, capacity_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   spq_rsp_type              rsp_ff, rsp_in;

   logic                     accept;
   spq_ctrl_type             ctrl;
   logic signed [31:0]       entry_w [CAPACITY];
   logic [CAPACITY-1:0]      ge_w;
   logic [CAPACITY-1:0]      le_w;
   logic [CAPACITY-1:0]      match_w;
   logic                     full;
   logic                     found;
   logic [1:0]               status;
   logic signed [31:0]       head_in;

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign full  = (CW'(count_ff) >= CW'(capacity_ff)) || (count_ff >= W'(CAPACITY));
   assign found = |match_w;

   always_comb begin
      ctrl.ins   = 1'b0;
      ctrl.del   = 1'b0;
      ctrl.value = item_ff.value;
      status     = ST_DONE;
      if (busy_ff) begin
         if (item_ff.func == FUNC_INSERT) begin
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.ins = 1'b1;
            end
         end else if (count_ff == '0) begin
            status = ST_EMPTY;
         end else if (!found) begin
            status = ST_NOTFOUND;
         end else begin
            ctrl.del = 1'b1;
         end
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic               left_ge;
      logic signed [31:0] left_entry;
      logic signed [31:0] right_entry;
      if (i == 0) begin : g_first
         assign left_ge    = 1'b0;
         assign left_entry = entry_w[0];
      end else begin : g_inner
         assign left_ge    = ge_w[i-1];
         assign left_entry = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_body
         assign right_entry = entry_w[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .cmp_en      (accept),
         .occupied    (count_ff > W'(i)),
         .cmp_value   (req_data.value),
         .ctrl        (ctrl),
         .left_ge     (left_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .ge          (ge_w[i]),
         .le          (le_w[i]),
         .match       (match_w[i])
      );
   end

   always_comb begin
      head_in = entry_w[0];
      if (ctrl.ins && ge_w[0]) begin
         head_in = item_ff.value;
      end else if (ctrl.del && le_w[0]) begin
         head_in = entry_w[1];
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      capacity_in  = capacity_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.ins) begin
         count_in = count_ff + W'(1);
      end else if (ctrl.del) begin
         count_in = count_ff - W'(1);
      end
      if (busy_ff) begin
         busy_in           = 1'b0;
         rsp_valid_in      = 1'b1;
         rsp_in.status     = status;
         rsp_in.count      = 7'(count_in);
         rsp_in.head_value = (count_in != '0) ? head_in : 32'sd0;
      end
      if (accept) begin
         busy_in = 1'b1;
         item_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
   import spq_pkg::*;

   localparam int CAP_DEPTH = 64;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      spq_req_type  req;
      logic [6:0]   cap;
      logic         typed;
      spq_rsp_type  outcome;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   spq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   spq_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [6:0]  csr_data;

   logic        row_typed;
   spq_rsp_type row_expect;
   logic        idling_on = 1'b1;

   int          shadow_entries[$];
   logic [6:0]  shadow_capacity = CAP_RESET;
   spq_rsp_type pending_outcomes[$];
   plan_row_type plan[$];
   spq_rsp_type outcome;
   spq_rsp_type seen;

   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int csr_writes = 0;
   int peak_count = 0;

   sorted_priority_queue_unit #(
      .CAPACITY(CAP_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic spq_rsp_type queue_update(spq_req_type item);
      spq_rsp_type res;
      int limit_now;
      int n;
      int pos;
      int v;
      int j;
      v = $signed(item.value);
      n = shadow_entries.size();
      limit_now = (shadow_capacity < CAP_DEPTH) ? shadow_capacity : CAP_DEPTH;
      res = '0;
      res.status = ST_DONE;
      if (item.func == FUNC_INSERT) begin
         if (n >= limit_now) begin
            res.status = ST_FULL;
         end else begin
            pos = n;
            for (j = 0; j < n; j++) begin
               if (pos == n && v >= shadow_entries[j]) pos = j;
            end
            shadow_entries.insert(pos, v);
         end
      end else if (n == 0) begin
         res.status = ST_EMPTY;
      end else begin
         pos = -1;
         for (j = 0; j < n; j++) begin
            if (pos < 0 && shadow_entries[j] == v) pos = j;
         end
         if (pos < 0) res.status = ST_NOTFOUND;
         else shadow_entries.delete(pos);
      end
      res.count = 7'(shadow_entries.size());
      res.head_value = (shadow_entries.size() != 0) ? shadow_entries[0] : 0;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_entries.delete();
         shadow_capacity = CAP_RESET;
      end else begin
         if (csr_valid && csr_ready) shadow_capacity = csr_data;
         if (req_valid && req_ready) begin
            outcome = queue_update(req_data);
            if (row_typed) outcome = row_expect;
            pending_outcomes.push_back(outcome);
            if (shadow_entries.size() > peak_count) peak_count = shadow_entries.size();
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            seen = rsp_data;
            if (pending_outcomes.size() == 0) begin
               $error("unexpected item: status %0d count %0d head %0d",
                      seen.status, seen.count, seen.head_value);
               mismatches++;
            end else begin
               outcome = pending_outcomes.pop_front();
               if (seen.status !== outcome.status) begin
                  $error("status mismatch: expected %0d, got %0d",
                         outcome.status, seen.status);
                  mismatches++;
               end
               if (seen.count !== outcome.count) begin
                  $error("count mismatch: expected %0d, got %0d",
                         outcome.count, seen.count);
                  mismatches++;
               end
               if (outcome.count != 0 && seen.head_value !== outcome.head_value) begin
                  $error("head_value mismatch: expected %0d, got %0d",
                         outcome.head_value, seen.head_value);
                  mismatches++;
               end
            end
         end
      end
   end

   function automatic void plan_item(logic f, logic [31:0] v);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.req.func = f;
      row.req.value = v;
      plan.push_back(row);
   endfunction

   function automatic void plan_known(logic f, logic [31:0] v, logic [1:0] st,
                                      logic [6:0] cnt, logic [31:0] hv);
      plan_row_type row;
      row = '0;
      row.kind = ROW_ITEM;
      row.req.func = f;
      row.req.value = v;
      row.typed = 1'b1;
      row.outcome.status = st;
      row.outcome.count = cnt;
      row.outcome.head_value = hv;
      plan.push_back(row);
   endfunction

   function automatic void plan_capacity(logic [6:0] c);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.cap = c;
      plan.push_back(row);
   endfunction

   task automatic send_item(logic f, logic [31:0] v, logic typed, spq_rsp_type res);
      spq_req_type item;
      item.func = f;
      item.value = v;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      row_typed <= typed;
      row_expect <= res;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic write_capacity(logic [6:0] c);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= c;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic random_item(int insert_pct);
      logic        f;
      logic [31:0] v;
      int          pick;
      f = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_DELETE;
      pick = $urandom_range(0, 9);
      if (f == FUNC_DELETE && shadow_entries.size() != 0 && pick < 7) begin
         v = shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      end else if (pick < 5) begin
         v = $urandom_range(0, 16) - 8;
      end else if (pick < 8) begin
         v = $urandom();
      end else if (pick == 8) begin
         v = 32'h7FFF_FFFF;
      end else begin
         v = 32'h8000_0000;
      end
      send_item(f, v, 1'b0, '0);
   endtask

   initial begin
      int stall_len;
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_len = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int phase;
      int cap;
      int pct;
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      row_typed <= 1'b0;
      row_expect <= '0;

      plan_known(FUNC_DELETE, 32'd5, ST_EMPTY, 7'd0, 32'd0);
      plan_known(FUNC_INSERT, 32'd0, ST_DONE, 7'd1, 32'd0);
      plan_known(FUNC_INSERT, 32'h7FFF_FFFF, ST_DONE, 7'd2, 32'h7FFF_FFFF);
      plan_known(FUNC_INSERT, 32'h8000_0000, ST_DONE, 7'd3, 32'h7FFF_FFFF);
      plan_item(FUNC_INSERT, 32'd7);
      plan_item(FUNC_INSERT, 32'd7);
      plan_item(FUNC_INSERT, 32'hFFFF_FFFF);
      plan_known(FUNC_DELETE, 32'd12345, ST_NOTFOUND, 7'd6, 32'h7FFF_FFFF);
      plan_item(FUNC_DELETE, 32'd7);
      plan_item(FUNC_DELETE, 32'h7FFF_FFFF);
      plan_item(FUNC_DELETE, 32'h8000_0000);
      plan_capacity(7'd0);
      plan_known(FUNC_INSERT, 32'd3, ST_FULL, 7'd3, 32'd7);
      plan_capacity(7'd2);
      plan_known(FUNC_INSERT, 32'd9, ST_FULL, 7'd3, 32'd7);
      plan_item(FUNC_DELETE, 32'd0);
      plan_known(FUNC_INSERT, 32'd9, ST_FULL, 7'd2, 32'd7);
      plan_item(FUNC_DELETE, 32'd7);
      plan_item(FUNC_DELETE, 32'hFFFF_FFFF);
      plan_known(FUNC_DELETE, 32'hFFFF_FFFF, ST_EMPTY, 7'd0, 32'd0);
      plan_capacity(7'd1);
      plan_item(FUNC_INSERT, 32'd5);
      plan_known(FUNC_INSERT, 32'd6, ST_FULL, 7'd1, 32'd5);
      plan_item(FUNC_DELETE, 32'd5);
      plan_capacity(7'd127);
      plan_item(FUNC_INSERT, 32'h5A5A_5A5A);
      plan_item(FUNC_INSERT, 32'hA5A5_A5A5);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_capacity(plan[i].cap);
         else send_item(plan[i].req.func, plan[i].req.value, plan[i].typed, plan[i].outcome);
      end

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin cap = 127; pct = 90; n = 100; end
            1: begin cap = 3; pct = 50; n = 60; end
            2: begin cap = 64; pct = 75; n = 80; end
            3: begin cap = 0; pct = 30; n = 40; end
            4: begin cap = 1; pct = 50; n = 50; end
            5: begin cap = $urandom_range(1, 127); pct = 60; n = 70; end
            default: begin cap = 64; pct = 55; n = 60; end
         endcase
         if (phase == 6) idling_on = 1'b0;
         write_capacity(7'(cap));
         repeat (n) random_item(pct);
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("checked %0d results from %0d items over %0d capacity writes",
               results_seen, items_sent, csr_writes);
      $display("queue filled to %0d entries at most", peak_count);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
